>>> hdl/svps_pkg.sv
`default_nettype none

package svps_pkg;

   // Default geometry of the valve and its timers
   localparam int POSITION_BITS_DEF = 12;
   localparam int DELAY_BITS_DEF    = 10;

   // Input word layout: target_position and open_then_close, padded to whole bytes
   localparam int TARGET_BITS   = 16;
   localparam int REQ_DATA_BITS = 24;
   localparam int REQ_USER_BITS = 2;
   localparam int CSR_INDEX_BITS = 3;

   // Register reset values
   localparam int MAX_POSITION_RST     = 480;
   localparam int ENERGIZE_DELAY_RST   = 500;
   localparam int STEP_PERIOD_RST      = 12;
   localparam int RELEASE_DELAY_RST    = 500;
   localparam int HOME_OPEN_STEPS_RST  = 500;
   localparam int HOME_CLOSE_STEPS_RST = 700;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_POSITION     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ENERGIZE_DELAY   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_PERIOD      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RELEASE_DELAY    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HOME_OPEN_STEPS  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HOME_CLOSE_STEPS = 3'd5;

   // Action codes
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_TARGET = 2'd1;
   localparam logic [1:0] ACT_HOME   = 2'd2;

   // Motion state codes, reported as they are
   localparam logic [2:0] MODE_IDLE       = 3'd0;
   localparam logic [2:0] MODE_ENERGIZE   = 3'd1;
   localparam logic [2:0] MODE_RUNNING    = 3'd2;
   localparam logic [2:0] MODE_SETTLE     = 3'd3;
   localparam logic [2:0] MODE_HOME_OPEN  = 3'd4;
   localparam logic [2:0] MODE_HOME_CLOSE = 3'd5;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] phase;
      logic       coils;
   } ctrl_type;

   // Half-step coil sequence: bit0 A1, bit1 A2, bit2 B1, bit3 B2
   function automatic logic [3:0] coil_lookup(input logic [2:0] phase);
      logic [3:0] pattern;
      case (phase)
         3'd0:    pattern = 4'd1;
         3'd1:    pattern = 4'd5;
         3'd2:    pattern = 4'd4;
         3'd3:    pattern = 4'd6;
         3'd4:    pattern = 4'd2;
         3'd5:    pattern = 4'd10;
         3'd6:    pattern = 4'd8;
         default: pattern = 4'd9;
      endcase
      return pattern;
   endfunction

endpackage

`default_nettype wire

>>> hdl/svps_step.sv
`default_nettype none

module svps_step #(
   parameter int POSITION_BITS = svps_pkg::POSITION_BITS_DEF,
   parameter int DELAY_BITS    = svps_pkg::DELAY_BITS_DEF
) (
   input  wire logic [1:0]                       action,
   input  wire logic [svps_pkg::TARGET_BITS-1:0] target_position,
   input  wire logic                             open_then_close,
   input  wire logic [POSITION_BITS-1:0]         max_position,
   input  wire logic [DELAY_BITS-1:0]            energize_delay,
   input  wire logic [DELAY_BITS-1:0]            step_period,
   input  wire logic [DELAY_BITS-1:0]            release_delay,
   input  wire logic [DELAY_BITS-1:0]            home_open_steps,
   input  wire logic [DELAY_BITS-1:0]            home_close_steps,
   input  wire svps_pkg::ctrl_type               ctrl_cur,
   input  wire logic [DELAY_BITS-1:0]            delay_cur,
   input  wire logic [POSITION_BITS-1:0]         pos_now_cur,
   input  wire logic [POSITION_BITS-1:0]         pos_goal_cur,
   input  wire logic [DELAY_BITS-1:0]            steps_left_cur,
   output svps_pkg::ctrl_type                    ctrl_nxt,
   output logic [DELAY_BITS-1:0]                 delay_nxt,
   output logic [POSITION_BITS-1:0]              pos_now_nxt,
   output logic [POSITION_BITS-1:0]              pos_goal_nxt,
   output logic [DELAY_BITS-1:0]                 steps_left_nxt,
   output logic                                  home_rejected
);
   import svps_pkg::*;

   logic                     expired;
   logic [DELAY_BITS-1:0]    delay_dec;
   logic [2:0]               phase_up;
   logic [2:0]               phase_dn;
   logic [TARGET_BITS-1:0]   limit_wide;

   // A delay of zero or one expires on this tick
   assign expired    = (delay_cur[DELAY_BITS-1:1] == '0);
   assign delay_dec  = expired ? '0 : delay_cur - 1'b1;
   assign phase_up   = ctrl_cur.phase + 3'd1;
   assign phase_dn   = ctrl_cur.phase - 3'd1;
   assign limit_wide = TARGET_BITS'(max_position);

   always_comb begin
      ctrl_nxt       = ctrl_cur;
      delay_nxt      = delay_cur;
      pos_now_nxt    = pos_now_cur;
      pos_goal_nxt   = pos_goal_cur;
      steps_left_nxt = steps_left_cur;
      home_rejected  = 1'b0;
      case (action)
         ACT_TICK: begin
            case (ctrl_cur.mode)
               MODE_IDLE: begin
                  if (pos_now_cur != pos_goal_cur) begin
                     ctrl_nxt.coils = 1'b1;
                     ctrl_nxt.mode  = MODE_ENERGIZE;
                     delay_nxt      = energize_delay;
                  end
               end
               MODE_ENERGIZE: begin
                  delay_nxt = delay_dec;
                  if (expired) begin
                     delay_nxt     = step_period;
                     ctrl_nxt.mode = MODE_RUNNING;
                  end
               end
               MODE_RUNNING: begin
                  delay_nxt = delay_dec;
                  if (expired) begin
                     if (pos_goal_cur > pos_now_cur) begin
                        ctrl_nxt.phase = phase_up;
                        ctrl_nxt.coils = 1'b1;
                        pos_now_nxt    = pos_now_cur + 1'b1;
                        delay_nxt      = step_period;
                     end else if (pos_goal_cur < pos_now_cur) begin
                        ctrl_nxt.phase = phase_dn;
                        ctrl_nxt.coils = 1'b1;
                        pos_now_nxt    = pos_now_cur - 1'b1;
                        delay_nxt      = step_period;
                     end else begin
                        delay_nxt     = release_delay;
                        ctrl_nxt.mode = MODE_SETTLE;
                     end
                  end
               end
               MODE_SETTLE: begin
                  delay_nxt = delay_dec;
                  if (expired) begin
                     ctrl_nxt.coils = 1'b0;
                     ctrl_nxt.mode  = MODE_IDLE;
                  end
               end
               MODE_HOME_OPEN: begin
                  delay_nxt = delay_dec;
                  if (expired) begin
                     if (steps_left_cur != '0) begin
                        ctrl_nxt.phase = phase_up;
                        ctrl_nxt.coils = 1'b1;
                        steps_left_nxt = steps_left_cur - 1'b1;
                        delay_nxt      = step_period;
                     end else if (home_close_steps == '0) begin
                        // nothing to close: finish right here
                        pos_now_nxt    = '0;
                        ctrl_nxt.mode  = MODE_IDLE;
                        delay_nxt      = '0;
                        steps_left_nxt = '0;
                     end else begin
                        ctrl_nxt.phase = phase_dn;
                        ctrl_nxt.coils = 1'b1;
                        steps_left_nxt = home_close_steps - 1'b1;
                        ctrl_nxt.mode  = MODE_HOME_CLOSE;
                        delay_nxt      = step_period;
                     end
                  end
               end
               MODE_HOME_CLOSE: begin
                  delay_nxt = delay_dec;
                  if (expired) begin
                     if (steps_left_cur != '0) begin
                        ctrl_nxt.phase = phase_dn;
                        ctrl_nxt.coils = 1'b1;
                        steps_left_nxt = steps_left_cur - 1'b1;
                        delay_nxt      = step_period;
                     end else begin
                        pos_now_nxt    = '0;
                        ctrl_nxt.mode  = MODE_IDLE;
                        delay_nxt      = '0;
                        steps_left_nxt = '0;
                     end
                  end
               end
               default: ctrl_nxt.mode = MODE_IDLE;
            endcase
         end
         ACT_TARGET: begin
            pos_goal_nxt = (target_position > limit_wide) ?
                           max_position : target_position[POSITION_BITS-1:0];
         end
         ACT_HOME: begin
            if (ctrl_cur.mode != MODE_IDLE) begin
               home_rejected = 1'b1;
            end else begin
               ctrl_nxt.coils = 1'b1;
               if (open_then_close && (home_open_steps != '0)) begin
                  ctrl_nxt.phase = phase_up;
                  steps_left_nxt = home_open_steps - 1'b1;
                  ctrl_nxt.mode  = MODE_HOME_OPEN;
                  delay_nxt      = step_period;
               end else if (home_close_steps == '0) begin
                  pos_now_nxt    = '0;
                  ctrl_nxt.mode  = MODE_IDLE;
                  delay_nxt      = '0;
                  steps_left_nxt = '0;
               end else begin
                  ctrl_nxt.phase = phase_dn;
                  steps_left_nxt = home_close_steps - 1'b1;
                  ctrl_nxt.mode  = MODE_HOME_CLOSE;
                  delay_nxt      = step_period;
               end
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/stepper_valve_position_sequencer_core.sv
`default_nettype none

// Half-step sequencer for a bipolar stepper valve.
//
// req channel: one word per event. tuser carries the action (tick, new target,
// start homing); tdata carries the target position and the open-then-close flag.
// rsp channel: exactly one status word per request word: coil drive pattern,
// actual and commanded position, motion state, phase and a homing-rejected flag.
// csr channel: register writes (index, data), always ready; write only while
// the sequencer is idle and the response pipe is drained.
//
// A request word is loaded into the input register when it is accepted, then
// carried through the step logic into the response register once that is free.
// Throughput is one word per cycle unless the receiver stalls; the combinational
// step logic is the only path between the two registers. When the receiver
// stalls, the response register holds and the input register keeps its word,
// so req_tready drops only once both are full. Reset clears registers to their
// defaults, puts the valve state at idle, position zero, coils off, and empties
// the pipe.

module stepper_valve_position_sequencer_core #(
   parameter int POSITION_BITS = svps_pkg::POSITION_BITS_DEF,
   parameter int DELAY_BITS    = svps_pkg::DELAY_BITS_DEF,
   localparam int CSR_DATA_BITS = (POSITION_BITS > DELAY_BITS) ? POSITION_BITS : DELAY_BITS,
   localparam int RSP_USED_BITS = 2 * POSITION_BITS + 11,
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [15:0] target_position, [16] open_then_close
   input  wire logic [svps_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [1:0] action
   input  wire logic [svps_pkg::REQ_USER_BITS-1:0]  req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [3:0] coil_pattern, then actual_position, command_position,
   // motion_state (3), phase_index (3), home_rejected (1)
   output logic [RSP_DATA_BITS-1:0]                 rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [svps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]            csr_data
);
   import svps_pkg::*;

   // configuration registers
   logic [POSITION_BITS-1:0] max_position_ff;
   logic [DELAY_BITS-1:0]    energize_delay_ff;
   logic [DELAY_BITS-1:0]    step_period_ff;
   logic [DELAY_BITS-1:0]    release_delay_ff;
   logic [DELAY_BITS-1:0]    home_open_steps_ff;
   logic [DELAY_BITS-1:0]    home_close_steps_ff;

   // input register
   logic                     in_valid_ff;
   logic [1:0]               in_action_ff;
   logic [TARGET_BITS-1:0]   in_target_ff;
   logic                     in_open_ff;

   // sequencer state
   ctrl_type                 ctrl_ff;
   ctrl_type                 ctrl_in;
   logic [DELAY_BITS-1:0]    delay_ff;
   logic [DELAY_BITS-1:0]    delay_in;
   logic [POSITION_BITS-1:0] pos_now_ff;
   logic [POSITION_BITS-1:0] pos_now_in;
   logic [POSITION_BITS-1:0] pos_goal_ff;
   logic [POSITION_BITS-1:0] pos_goal_in;
   logic [DELAY_BITS-1:0]    steps_left_ff;
   logic [DELAY_BITS-1:0]    steps_left_in;
   logic                     rejected_in;

   // response register
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_in;

   logic                     rsp_free;
   logic                     advance;
   logic                     req_take;
   logic [3:0]               coil_in;

   // A word moves from the input register to the response register whenever
   // the response slot is empty or being drained this cycle.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   svps_step #(
      .POSITION_BITS (POSITION_BITS),
      .DELAY_BITS    (DELAY_BITS)
   ) u_step (
      .action           (in_action_ff),
      .target_position  (in_target_ff),
      .open_then_close  (in_open_ff),
      .max_position     (max_position_ff),
      .energize_delay   (energize_delay_ff),
      .step_period      (step_period_ff),
      .release_delay    (release_delay_ff),
      .home_open_steps  (home_open_steps_ff),
      .home_close_steps (home_close_steps_ff),
      .ctrl_cur         (ctrl_ff),
      .delay_cur        (delay_ff),
      .pos_now_cur      (pos_now_ff),
      .pos_goal_cur     (pos_goal_ff),
      .steps_left_cur   (steps_left_ff),
      .ctrl_nxt         (ctrl_in),
      .delay_nxt        (delay_in),
      .pos_now_nxt      (pos_now_in),
      .pos_goal_nxt     (pos_goal_in),
      .steps_left_nxt   (steps_left_in),
      .home_rejected    (rejected_in)
   );

   // Coils read as all off when de-energized
   assign coil_in = ctrl_in.coils ? coil_lookup(ctrl_in.phase) : 4'd0;

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_USED_BITS-1:0] = {rejected_in, ctrl_in.phase, ctrl_in.mode,
                                        pos_goal_in, pos_now_in, coil_in};
   end

   // control state, configuration and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         max_position_ff     <= POSITION_BITS'(MAX_POSITION_RST);
         energize_delay_ff   <= DELAY_BITS'(ENERGIZE_DELAY_RST);
         step_period_ff      <= DELAY_BITS'(STEP_PERIOD_RST);
         release_delay_ff    <= DELAY_BITS'(RELEASE_DELAY_RST);
         home_open_steps_ff  <= DELAY_BITS'(HOME_OPEN_STEPS_RST);
         home_close_steps_ff <= DELAY_BITS'(HOME_CLOSE_STEPS_RST);
         ctrl_ff             <= '{mode: MODE_IDLE, phase: 3'd0, coils: 1'b0};
         delay_ff            <= '0;
         pos_now_ff          <= '0;
         pos_goal_ff         <= '0;
         steps_left_ff       <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         // advance the sequencer once per word
         if (advance) begin
            ctrl_ff       <= ctrl_in;
            delay_ff      <= delay_in;
            pos_now_ff    <= pos_now_in;
            pos_goal_ff   <= pos_goal_in;
            steps_left_ff <= steps_left_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAX_POSITION:     max_position_ff     <= csr_data[POSITION_BITS-1:0];
               REG_ENERGIZE_DELAY:   energize_delay_ff   <= csr_data[DELAY_BITS-1:0];
               REG_STEP_PERIOD:      step_period_ff      <= csr_data[DELAY_BITS-1:0];
               REG_RELEASE_DELAY:    release_delay_ff    <= csr_data[DELAY_BITS-1:0];
               REG_HOME_OPEN_STEPS:  home_open_steps_ff  <= csr_data[DELAY_BITS-1:0];
               REG_HOME_CLOSE_STEPS: home_close_steps_ff <= csr_data[DELAY_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload: capture on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_tuser;
         in_target_ff <= req_tdata[TARGET_BITS-1:0];
         in_open_ff   <= req_tdata[TARGET_BITS];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // coils are only ever off while idle
   assert property (@(posedge clock) disable iff (reset)
      !ctrl_ff.coils |-> (ctrl_ff.mode == MODE_IDLE))
      else $error("coils off outside idle");

   // phase moves at most one half step per word
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (ctrl_ff.phase == $past(ctrl_ff.phase)) ||
               (ctrl_ff.phase == $past(ctrl_ff.phase) + 3'd1) ||
               (ctrl_ff.phase == $past(ctrl_ff.phase) - 3'd1))
      else $error("phase jumped by more than one half step");

   // actual position holds while homing is under way
   assert property (@(posedge clock) disable iff (reset)
      ((ctrl_ff.mode == MODE_HOME_OPEN) || (ctrl_ff.mode == MODE_HOME_CLOSE)) &&
      ((ctrl_in.mode == MODE_HOME_OPEN) || (ctrl_in.mode == MODE_HOME_CLOSE))
      |-> (pos_now_in == pos_now_ff))
      else $error("position changed during homing");

   // a rejected homing request is only reported outside idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[RSP_USED_BITS-1] |->
      (rsp_data_ff[2*POSITION_BITS+6:2*POSITION_BITS+4] != MODE_IDLE))
      else $error("homing rejected while idle");

endmodule

`default_nettype wire

>>> test/stepper_valve_position_sequencer_core_tb.sv
`timescale 1ns / 100ps

module stepper_valve_position_sequencer_core_tb;
   import svps_pkg::*;

   localparam int CSR_BITS       = 12;
   localparam int RSP_BITS       = 40;
   localparam int WATCHDOG_LIMIT = 3000;

   // The one action code the block has no use for
   localparam logic [1:0] ACT_SPARE = 2'd3;

   // Half-step coil drive, four bits per phase, phase 0 in the lowest nibble
   localparam logic [31:0] COIL_SEQUENCE =
      {4'd9, 4'd8, 4'd10, 4'd2, 4'd6, 4'd4, 4'd5, 4'd1};

   // Status word as it sits in rsp_tdata, lowest field last
   typedef struct packed {
      logic        rejected;
      logic [2:0]  phase;
      logic [2:0]  mode;
      logic [11:0] command;
      logic [11:0] actual;
      logic [3:0]  coil;
   } valve_status_type;

   // Tracks the valve state on its own and holds the status words still owed
   class valve_status_board;
      logic [11:0]      max_pos;
      logic [9:0]       energize_ticks;
      logic [9:0]       step_ticks;
      logic [9:0]       release_ticks;
      logic [9:0]       open_steps;
      logic [9:0]       close_steps;
      logic [2:0]       mode;
      logic [9:0]       countdown;
      logic [2:0]       phase;
      logic [11:0]      pos_now;
      logic [11:0]      pos_goal;
      logic [9:0]       steps_left;
      bit               coils_on;
      valve_status_type status_q[$];
      int               errors;
      int               words_seen;
      int               homes_taken;
      int               homes_refused;

      function new();
         max_pos        = 12'(MAX_POSITION_RST);
         energize_ticks = 10'(ENERGIZE_DELAY_RST);
         step_ticks     = 10'(STEP_PERIOD_RST);
         release_ticks  = 10'(RELEASE_DELAY_RST);
         open_steps     = 10'(HOME_OPEN_STEPS_RST);
         close_steps    = 10'(HOME_CLOSE_STEPS_RST);
         mode           = MODE_IDLE;
         countdown      = '0;
         phase          = '0;
         pos_now        = '0;
         pos_goal       = '0;
         steps_left     = '0;
         coils_on       = 1'b0;
         errors         = 0;
         words_seen     = 0;
         homes_taken    = 0;
         homes_refused  = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [11:0] value);
         case (index)
            REG_MAX_POSITION:     max_pos        = value;
            REG_ENERGIZE_DELAY:   energize_ticks = value[9:0];
            REG_STEP_PERIOD:      step_ticks     = value[9:0];
            REG_RELEASE_DELAY:    release_ticks  = value[9:0];
            REG_HOME_OPEN_STEPS:  open_steps     = value[9:0];
            REG_HOME_CLOSE_STEPS: close_steps    = value[9:0];
            default: ;
         endcase
      endfunction

      // A count of zero or one runs out on the next tick
      function bit countdown_expired();
         if (countdown <= 10'd1) begin
            countdown = '0;
            return 1'b1;
         end
         countdown = countdown - 10'd1;
         return 1'b0;
      endfunction

      function void half_step(bit opening);
         phase    = opening ? phase + 3'd1 : phase - 3'd1;
         coils_on = 1'b1;
      endfunction

      function void home_done();
         pos_now    = '0;
         mode       = MODE_IDLE;
         countdown  = '0;
         steps_left = '0;
      endfunction

      function void home_close_start();
         if (close_steps == '0) begin
            home_done();
            return;
         end
         half_step(1'b0);
         steps_left = close_steps - 10'd1;
         mode       = MODE_HOME_CLOSE;
         countdown  = step_ticks;
      endfunction

      function void note_word(logic [1:0] action, logic [15:0] target, bit open_then_close);
         valve_status_type st;
         bit               refused;
         refused = 1'b0;
         words_seen++;
         case (action)
            ACT_TICK: begin
               case (mode)
                  MODE_IDLE: begin
                     if (pos_now != pos_goal) begin
                        coils_on  = 1'b1;
                        countdown = energize_ticks;
                        mode      = MODE_ENERGIZE;
                     end
                  end
                  MODE_ENERGIZE: begin
                     if (countdown_expired()) begin
                        countdown = step_ticks;
                        mode      = MODE_RUNNING;
                     end
                  end
                  MODE_RUNNING: begin
                     if (countdown_expired()) begin
                        if (pos_goal > pos_now) begin
                           half_step(1'b1);
                           pos_now   = pos_now + 12'd1;
                           countdown = step_ticks;
                        end else if (pos_goal < pos_now) begin
                           half_step(1'b0);
                           pos_now   = pos_now - 12'd1;
                           countdown = step_ticks;
                        end else begin
                           countdown = release_ticks;
                           mode      = MODE_SETTLE;
                        end
                     end
                  end
                  MODE_SETTLE: begin
                     if (countdown_expired()) begin
                        coils_on = 1'b0;
                        mode     = MODE_IDLE;
                     end
                  end
                  MODE_HOME_OPEN: begin
                     if (countdown_expired()) begin
                        if (steps_left != '0) begin
                           half_step(1'b1);
                           steps_left = steps_left - 10'd1;
                           countdown  = step_ticks;
                        end else begin
                           home_close_start();
                        end
                     end
                  end
                  MODE_HOME_CLOSE: begin
                     if (countdown_expired()) begin
                        if (steps_left != '0) begin
                           half_step(1'b0);
                           steps_left = steps_left - 10'd1;
                           countdown  = step_ticks;
                        end else begin
                           home_done();
                        end
                     end
                  end
                  default: mode = MODE_IDLE;
               endcase
            end
            ACT_TARGET: begin
               pos_goal = (target > {4'd0, max_pos}) ? max_pos : target[11:0];
            end
            ACT_HOME: begin
               if (mode != MODE_IDLE) begin
                  refused = 1'b1;
                  homes_refused++;
               end else begin
                  coils_on = 1'b1;
                  homes_taken++;
                  if (open_then_close && open_steps != '0) begin
                     half_step(1'b1);
                     steps_left = open_steps - 10'd1;
                     mode       = MODE_HOME_OPEN;
                     countdown  = step_ticks;
                  end else begin
                     home_close_start();
                  end
               end
            end
            default: ;
         endcase
         st.coil     = coils_on ? COIL_SEQUENCE[{phase, 2'b00} +: 4] : 4'd0;
         st.actual   = pos_now;
         st.command  = pos_goal;
         st.mode     = mode;
         st.phase    = phase;
         st.rejected = refused;
         status_q.push_back(st);
      endfunction

      function void compare_field(string name, logic [11:0] want, logic [11:0] got);
         if (got !== want) begin
            $display("%0t ERROR: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_word(logic [RSP_BITS-1:0] data);
         valve_status_type got;
         valve_status_type want;
         got = data[$bits(valve_status_type)-1:0];
         if (status_q.size() == 0) begin
            $display("%0t ERROR: status word %h with no request waiting", $time, data);
            errors++;
            return;
         end
         want = status_q.pop_front();
         compare_field("coil_pattern", want.coil, got.coil);
         compare_field("actual_position", want.actual, got.actual);
         compare_field("command_position", want.command, got.command);
         compare_field("motion_state", want.mode, got.mode);
         compare_field("phase_index", want.phase, got.phase);
         compare_field("home_rejected", want.rejected, got.rejected);
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // [15:0] target_position, [16] open_then_close, [23:17] zero
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   // [1:0] action
   logic [REQ_USER_BITS-1:0]  req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // [3:0] coil_pattern, [15:4] actual_position, [27:16] command_position,
   // [30:28] motion_state, [33:31] phase_index, [34] home_rejected
   logic [RSP_BITS-1:0]       rsp_tdata;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_BITS-1:0]       csr_data = '0;

   valve_status_board sb;
   bit                quiet = 1'b0;
   int                stall_left = 0;
   int                idle_cycles = 0;
   int                settings_applied = 0;

   stepper_valve_position_sequencer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Receiver side: stall at random, never once the run goes quiet
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check every status word as it is taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_word(rsp_tdata);
      end
   end

   // Count cycles with no handshake anywhere; give up on a hung block
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ERROR: no handshake for %0d cycles", $time, idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // After a random gap unless quiet, present one request word, hold it until taken, then log it with the tracker
   task automatic send_word(input logic [1:0] action, input logic [15:0] target,
                            input bit open_then_close);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {7'd0, open_then_close, target};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(action, target, open_then_close);
   endtask

   // Drop the request, then wait until every status word has come back
   task automatic wait_drained(input int extra);
      req_tvalid <= 1'b0;
      while (sb.status_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Hold csr_valid across the writes; the caller lowers it afterwards
   task automatic write_csr(input logic [2:0] index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[CSR_BITS-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(index, value[CSR_BITS-1:0]);
   endtask

   task automatic program_valve(input int max_pos, input int energize, input int step,
                                input int release_ticks, input int open_n, input int close_n);
      wait_drained(4);
      write_csr(REG_MAX_POSITION, max_pos);
      write_csr(REG_ENERGIZE_DELAY, energize);
      write_csr(REG_STEP_PERIOD, step);
      write_csr(REG_RELEASE_DELAY, release_ticks);
      write_csr(REG_HOME_OPEN_STEPS, open_n);
      write_csr(REG_HOME_CLOSE_STEPS, close_n);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic program_small();
      program_valve($urandom_range(8, 200), $urandom_range(1, 4), $urandom_range(1, 3),
                    $urandom_range(1, 4), $urandom_range(0, 4), $urandom_range(0, 4));
   endtask

   // Park the target on the present position, tick until the valve is at rest,
   // then park again in case homing moved the actual position to zero
   task automatic return_to_idle();
      send_word(ACT_TARGET, {4'd0, sb.pos_now}, 1'($urandom_range(0, 1)));
      while (sb.mode != MODE_IDLE) begin
         send_word(ACT_TICK, 16'($urandom), 1'($urandom_range(0, 1)));
      end
      send_word(ACT_TARGET, {4'd0, sb.pos_now}, 1'($urandom_range(0, 1)));
   endtask

   // Mostly ticks so that motion and homing run through, with targets, homing and noise
   task automatic random_words(input int count);
      int          pick;
      int          spread;
      logic [1:0]  action;
      logic [15:0] target;
      for (int i = 0; i < count; i++) begin
         pick   = $urandom_range(0, 99);
         spread = $urandom_range(0, 99);
         if (spread < 80) target = 16'($urandom_range(0, 40));
         else if (spread < 95) target = 16'($urandom);
         else target = 16'hFFFF;
         if (pick < 68) action = ACT_TICK;
         else if (pick < 84) action = ACT_TARGET;
         else if (pick < 95) action = ACT_HOME;
         else action = ACT_SPARE;
         send_word(action, target, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset values: tick at rest, clamp a full-scale target, take it back
      send_word(ACT_TICK, 16'h0000, 1'b0);
      send_word(ACT_TARGET, 16'hFFFF, 1'b1);
      send_word(ACT_TARGET, 16'h0000, 1'b0);

      // Short timers: move three steps, refuse homing while moving, settle, release
      program_valve(100, 2, 1, 2, 3, 2);
      send_word(ACT_TARGET, 16'd3, 1'b0);
      send_word(ACT_TICK, 16'hA5A5, 1'b1);
      send_word(ACT_HOME, 16'h0000, 1'b1);
      repeat (9) send_word(ACT_TICK, 16'h0000, 1'b0);
      // Home opening first, then closing only, and clamp a full-scale target
      send_word(ACT_HOME, 16'h5A5A, 1'b1);
      repeat (5) send_word(ACT_TICK, 16'h0000, 1'b0);
      send_word(ACT_HOME, 16'h0000, 1'b0);
      repeat (3) send_word(ACT_TICK, 16'h0000, 1'b0);
      send_word(ACT_TARGET, 16'hFFFF, 1'b0);
      send_word(ACT_SPARE, 16'hFFFF, 1'b1);
      return_to_idle();

      // Random phases over several settings, the extremes among them
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            1:       program_valve(4095, 0, 0, 0, 0, 0);
            2:       program_valve(0, 1, 1, 1, 1, 1);
            5:       program_valve($urandom_range(0, 4095), $urandom_range(1, 20),
                                   $urandom_range(1, 8), $urandom_range(1, 20),
                                   $urandom_range(0, 10), $urandom_range(0, 10));
            default: program_small();
         endcase
         random_words(85);
         return_to_idle();
      end

      // Longest timers and widest clamp, with no idling on either side
      program_valve(4095, 1023, 1023, 1023, 1023, 1023);
      quiet = 1'b1;
      random_words(50);
      wait_drained(10);

      sb.errors += sb.status_q.size();
      $display("Summary: %0d request words over %0d register settings",
               sb.words_seen, settings_applied);
      $display("Summary: %0d homing runs started, %0d homing requests refused",
               sb.homes_taken, sb.homes_refused);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
